/* rtl/sdf_pkg.sv */
// Shared constants, codes and helper functions for the smoothstep dimmer fade block.
`default_nettype none

package sdf_pkg;

    // Field widths
    localparam int ACTION_W  = 3;
    localparam int LEVEL_W   = 8;
    localparam int DUTY_W    = 7;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;

    // Fade step counter width and its saturation value
    localparam int STEP_COUNT_BITS = 10;
    localparam int STEP_W          = STEP_COUNT_BITS;
    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    // Fixed-point unity of the curve, and the datapath widths of the shared unit
    localparam int FP_W     = 16;
    localparam logic [FP_W-1:0] FP_ONE = '1;
    localparam int MUL_A_W  = 16;
    localparam int MUL_B_W  = 18;
    localparam int DIV_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_ITER = 18;
    localparam int CNT_W    = $clog2(DIV_ITER);
    localparam logic [MUL_B_W-1:0] THREE_FP = MUL_B_W'(3 * 65535);

    // Level handling
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd254;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 8'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_ON  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_OFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_LVL = 2'd2;

    localparam logic [CFG_W-1:0] CFG_ON_RST  = 10'd45;
    localparam logic [CFG_W-1:0] CFG_OFF_RST = 10'd35;
    localparam logic [CFG_W-1:0] CFG_LVL_RST = 10'd30;

    // Action codes carried by an input item
    typedef enum logic [ACTION_W-1:0] {
        ACT_SET_POWER = 3'd0,
        ACT_SET_LEVEL = 3'd1,
        ACT_TICK      = 3'd2,
        ACT_FAULT_OFF = 3'd3,
        ACT_RECOVER   = 3'd4,
        ACT_SYNC      = 3'd5
    } action_t;

    // Level to percent, lv*100/254, by reciprocal multiply (exact over 0..255)
    function automatic logic [DUTY_W-1:0] level_pct(input logic [LEVEL_W-1:0] lv);
        logic [14:0] scaled;
        logic [31:0] prod;
        scaled = 15'(lv) * 15'd100;
        prod   = 32'(scaled) * 32'd66053;
        return DUTY_W'(prod >> 24);
    endfunction

    // Fade length from a register: zero reads as one, large values saturate
    function automatic logic [STEP_W-1:0] steps_of(input logic [CFG_W-1:0] n);
        logic [CFG_W+STEP_W-1:0] wide;
        wide = (CFG_W + STEP_W)'(n);
        if (n == '0)
            return STEP_W'(1);
        else if (wide > (CFG_W + STEP_W)'(STEP_MAX))
            return STEP_MAX;
        else
            return STEP_W'(wide);
    endfunction

endpackage

`default_nettype wire

/* rtl/sdf_in_if.sv */
// Input item channel: valid/ready handshake with the action payload.
`default_nettype none

interface sdf_in_if;
    import sdf_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                on_value;
    logic [LEVEL_W-1:0]  level_value;
    logic                fault_active;
    logic                turn_on_blocked;

    modport source (
        output valid, action, on_value, level_value, fault_active, turn_on_blocked,
        input  ready
    );

    modport sink (
        input  valid, action, on_value, level_value, fault_active, turn_on_blocked,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/sdf_out_if.sv */
// Result channel: valid/ready handshake with the dimmer status payload.
`default_nettype none

interface sdf_out_if;
    import sdf_pkg::*;

    logic               valid;
    logic               ready;
    logic [DUTY_W-1:0]  duty_percent;
    logic               output_enabled;
    logic               fade_running;
    logic               light_on;
    logic [LEVEL_W-1:0] level_now;

    modport source (
        output valid, duty_percent, output_enabled, fade_running, light_on, level_now,
        input  ready
    );

    modport sink (
        input  valid, duty_percent, output_enabled, fade_running, light_on, level_now,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/smoothstep_dimmer_fade.sv */
// All actions but a mid-fade tick go from S_IDLE to S_OUT, then load the output register.
// A mid-fade tick runs four multiply/divide passes on one shared multiplier and one
// radix-2 divider, each pass an S_MUL step followed by S_DIV, before it reaches S_OUT.
// A new item is taken only in S_IDLE, once the previous result is loaded; it is taken
// while the previous result still waits on the output register.
// Reset (rst_n low, async): light off, level 254, output routed, registers 45/35/30.
`default_nettype none

module smoothstep_dimmer_fade (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    sdf_in_if.sink                          item,
    sdf_out_if.source                       result,
    input  wire logic                       cfg_we,
    input  wire logic [sdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sdf_pkg::CFG_W-1:0]  cfg_wdata
);
    import sdf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    // Architectural state
    logic               on_reg, on_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [DUTY_W-1:0]  shown_reg, shown_next;
    logic [DUTY_W-1:0]  from_reg, from_next;
    logic [DUTY_W-1:0]  to_reg, to_next;
    logic [STEP_W-1:0]  idx_reg, idx_next;
    logic [STEP_W-1:0]  len_reg, len_next;
    logic               fading_reg, fading_next;
    logic               routed_reg, routed_next;
    logic               saved_valid_reg, saved_valid_next;
    logic               saved_on_reg, saved_on_next;
    logic [LEVEL_W-1:0] saved_level_reg, saved_level_next;

    // Configuration registers
    logic [CFG_W-1:0]   cfg_on_reg, cfg_off_reg, cfg_lvl_reg;

    // Sequencer
    state_t             state_reg, state_next;
    logic [1:0]         phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // Shared datapath
    logic [FP_W-1:0]    rem_reg, rem_next;
    logic [DIV_ITER-1:0] quo_reg, quo_next;
    logic [FP_W-1:0]    t_reg, t_next;
    logic [FP_W-1:0]    val_reg, val_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]  out_duty_reg;
    logic               out_en_reg, out_fade_reg, out_on_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               out_load;

    // Decode helpers
    logic               accept;
    logic               go_arith;
    logic [LEVEL_W-1:0] pwr_level;
    logic               sch_on, sch_restart;
    logic [LEVEL_W-1:0] sch_level;
    logic [DUTY_W-1:0]  sch_target, sch_from;
    logic [STEP_W-1:0]  sch_len;
    logic               rest_on;
    logic [LEVEL_W-1:0] rest_level;
    logic               now_on;
    logic [LEVEL_W-1:0] now_level;
    logic [DUTY_W-1:0]  now_duty;
    logic [STEP_W-1:0]  idx_inc;

    // Arithmetic helpers
    logic               delta_neg;
    logic [DUTY_W-1:0]  delta_abs;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [DIV_W-1:0]   product;
    logic [FP_W-1:0]    divisor;
    logic [FP_W:0]      trial, trial_diff;
    logic               trial_ge;
    logic [DIV_ITER-1:0] quo_step;

    assign accept      = item.valid && item.ready;
    assign item.ready  = (state_reg == S_IDLE);

    // Power-on level fix-up: a near-zero level turns on at full
    assign pwr_level   = (item.on_value && (level_reg <= LEVEL_LOW)) ? LEVEL_FULL : level_reg;

    // Fade scheduling inputs, shared by set power and set level
    assign sch_restart = (item.action == ACT_SET_POWER);
    assign sch_on      = sch_restart ? item.on_value : on_reg;
    assign sch_level   = sch_restart ? pwr_level : item.level_value;
    assign sch_target  = sch_on ? level_pct(sch_level) : '0;
    assign sch_from    = (!fading_reg || sch_restart) ? shown_reg : from_reg;
    assign sch_len     = sch_on ? steps_of(sch_restart ? cfg_on_reg : cfg_lvl_reg)
                                : steps_of(cfg_off_reg);

    // Immediate apply, shared by recover and sync
    assign rest_on     = saved_valid_reg ? saved_on_reg : on_reg;
    assign rest_level  = saved_valid_reg ? saved_level_reg : level_reg;
    assign now_on      = (item.action == ACT_RECOVER) ? rest_on : item.on_value;
    assign now_level   = (item.action == ACT_RECOVER) ? rest_level : item.level_value;
    assign now_duty    = now_on ? level_pct(now_level) : '0;

    assign idx_inc     = idx_reg + STEP_W'(1);

    // Interpolation span, handled as magnitude and sign for truncating division
    assign delta_neg   = (to_reg < from_reg);
    assign delta_abs   = delta_neg ? (from_reg - to_reg) : (to_reg - from_reg);

    // Shared multiplier operands per pass: t, t^2, smoothstep, scaled span
    always_comb
    begin
        unique case (phase_reg)
            2'd0:
            begin
                mul_a = MUL_A_W'(idx_reg);
                mul_b = MUL_B_W'(FP_ONE);
            end
            2'd1:
            begin
                mul_a = t_reg;
                mul_b = MUL_B_W'(t_reg);
            end
            2'd2:
            begin
                mul_a = val_reg;
                mul_b = THREE_FP - {1'b0, t_reg, 1'b0};
            end
            default:
            begin
                mul_a = MUL_A_W'(delta_abs);
                mul_b = MUL_B_W'(val_reg);
            end
        endcase
    end

    assign product = DIV_W'(mul_a) * DIV_W'(mul_b);
    assign divisor = (phase_reg == 2'd0) ? FP_W'(len_reg) : FP_ONE;

    // Restoring divider step: one quotient bit a cycle
    assign trial      = {rem_reg, quo_reg[DIV_ITER-1]};
    assign trial_diff = trial - {1'b0, divisor};
    assign trial_ge   = (trial >= {1'b0, divisor});
    assign quo_step   = {quo_reg[DIV_ITER-2:0], trial_ge};

    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    // Next-state logic for the sequencer and the dimmer state
    always_comb
    begin
        on_next          = on_reg;
        level_next       = level_reg;
        shown_next       = shown_reg;
        from_next        = from_reg;
        to_next          = to_reg;
        idx_next         = idx_reg;
        len_next         = len_reg;
        fading_next      = fading_reg;
        routed_next      = routed_reg;
        saved_valid_next = saved_valid_reg;
        saved_on_next    = saved_on_reg;
        saved_level_next = saved_level_reg;
        state_next       = state_reg;
        phase_next       = phase_reg;
        cnt_next         = cnt_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        t_next           = t_reg;
        val_next         = val_reg;
        go_arith         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.action)
                        ACT_SET_POWER, ACT_SET_LEVEL:
                        begin
                            if (sch_restart)
                            begin
                                if (!(item.on_value && item.turn_on_blocked))
                                begin
                                    on_next    = item.on_value;
                                    level_next = pwr_level;
                                end
                            end
                            else
                                level_next = item.level_value;

                            if ((sch_restart && !(item.on_value && item.turn_on_blocked))
                                || (!sch_restart && on_reg))
                            begin
                                if (item.fault_active)
                                begin
                                    fading_next = 1'b0;
                                    routed_next = 1'b0;
                                end
                                else
                                begin
                                    to_next     = sch_target;
                                    from_next   = sch_from;
                                    routed_next = 1'b1;
                                    if (sch_from == sch_target)
                                    begin
                                        fading_next = 1'b0;
                                        shown_next  = sch_target;
                                    end
                                    else
                                    begin
                                        idx_next    = '0;
                                        len_next    = sch_len;
                                        fading_next = 1'b1;
                                        shown_next  = sch_from;
                                    end
                                end
                            end
                        end
                        ACT_TICK:
                        begin
                            if (!fading_reg || item.fault_active)
                                fading_next = 1'b0;
                            else
                            begin
                                idx_next    = idx_inc;
                                routed_next = 1'b1;
                                if (idx_inc >= len_reg)
                                begin
                                    fading_next = 1'b0;
                                    shown_next  = to_reg;
                                end
                                else
                                    go_arith = 1'b1;
                            end
                        end
                        ACT_FAULT_OFF:
                        begin
                            if (!saved_valid_reg)
                            begin
                                saved_on_next    = on_reg;
                                saved_level_next = level_reg;
                                saved_valid_next = 1'b1;
                            end
                            fading_next = 1'b0;
                            on_next     = 1'b0;
                            shown_next  = '0;
                            routed_next = 1'b0;
                        end
                        ACT_RECOVER, ACT_SYNC:
                        begin
                            if (item.action == ACT_RECOVER)
                                saved_valid_next = 1'b0;
                            on_next     = now_on;
                            level_next  = now_level;
                            fading_next = 1'b0;
                            routed_next = !item.fault_active;
                            if (!item.fault_active)
                                shown_next = now_duty;
                        end
                        default:
                        begin
                        end
                    endcase
                    phase_next = 2'd0;
                    state_next = go_arith ? S_MUL : S_OUT;
                end
            end
            S_MUL:
            begin
                // Registered product seeds the divider
                rem_next   = product[DIV_W-1:DIV_ITER];
                quo_next   = product[DIV_ITER-1:0];
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = trial_ge ? trial_diff[FP_W-1:0] : trial[FP_W-1:0];
                quo_next = quo_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_ITER - 1))
                begin
                    unique case (phase_reg)
                        2'd0:    t_next   = quo_step[FP_W-1:0];
                        2'd1:    val_next = quo_step[FP_W-1:0];
                        2'd2:    val_next = quo_step[FP_W-1:0];
                        default: shown_next = delta_neg ? (from_reg - quo_step[DUTY_W-1:0])
                                                        : (from_reg + quo_step[DUTY_W-1:0]);
                    endcase
                    phase_next = phase_reg + 2'd1;
                    state_next = (phase_reg == 2'd3) ? S_OUT : S_MUL;
                end
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared once the transfer completes
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control and dimmer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= 2'd0;
            cnt_reg         <= '0;
            on_reg          <= 1'b0;
            level_reg       <= LEVEL_FULL;
            shown_reg       <= '0;
            from_reg        <= '0;
            to_reg          <= '0;
            idx_reg         <= '0;
            len_reg         <= '0;
            fading_reg      <= 1'b0;
            routed_reg      <= 1'b1;
            saved_valid_reg <= 1'b0;
            saved_on_reg    <= 1'b0;
            saved_level_reg <= LEVEL_FULL;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            cnt_reg         <= cnt_next;
            on_reg          <= on_next;
            level_reg       <= level_next;
            shown_reg       <= shown_next;
            from_reg        <= from_next;
            to_reg          <= to_next;
            idx_reg         <= idx_next;
            len_reg         <= len_next;
            fading_reg      <= fading_next;
            routed_reg      <= routed_next;
            saved_valid_reg <= saved_valid_next;
            saved_on_reg    <= saved_on_next;
            saved_level_reg <= saved_level_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_on_reg  <= CFG_ON_RST;
            cfg_off_reg <= CFG_OFF_RST;
            cfg_lvl_reg <= CFG_LVL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEPS_ON:  cfg_on_reg  <= cfg_wdata;
                CFG_STEPS_OFF: cfg_off_reg <= cfg_wdata;
                CFG_STEPS_LVL: cfg_lvl_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Datapath and result payload
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        t_reg   <= t_next;
        val_reg <= val_next;
        if (out_load)
        begin
            out_duty_reg  <= routed_reg ? shown_reg : '0;
            out_en_reg    <= routed_reg;
            out_fade_reg  <= fading_reg;
            out_on_reg    <= on_reg;
            out_level_reg <= level_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.duty_percent   = out_duty_reg;
    assign result.output_enabled = out_en_reg;
    assign result.fade_running   = out_fade_reg;
    assign result.light_on       = out_on_reg;
    assign result.level_now      = out_level_reg;

endmodule

`default_nettype wire

/* dv/sdf_fade_checker.sv */
// Status checker for the smoothstep dimmer: predicts each result and compares transfers.
module sdf_fade_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    sdf_in_if                             item_ch,
    sdf_out_if                            result_ch,
    input  logic                          cfg_we,
    input  logic [sdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sdf_pkg::CFG_W-1:0]     cfg_wdata,
    output int                            fail_count,
    output int                            outstanding
);
    import sdf_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic               enabled;
        logic               fading;
        logic               on;
        logic [LEVEL_W-1:0] level;
    } status_t;

    // Fade lengths as last written
    logic [CFG_W-1:0]   steps_cfg [3];

    // Predicted dimmer state
    logic               light_on;
    logic [LEVEL_W-1:0] level_reg;
    logic [DUTY_W-1:0]  shown;
    logic [DUTY_W-1:0]  from_duty;
    logic [DUTY_W-1:0]  to_duty;
    logic [STEP_W-1:0]  step_pos;
    logic [STEP_W-1:0]  step_total;
    logic               fade_busy;
    logic               routed;
    logic               saved_ok;
    logic               saved_on;
    logic [LEVEL_W-1:0] saved_level;
    logic               fault_in;

    status_t            status_q [$];
    int                 mismatches;

    function automatic void clear_model();
        steps_cfg[CFG_STEPS_ON]  = CFG_ON_RST;
        steps_cfg[CFG_STEPS_OFF] = CFG_OFF_RST;
        steps_cfg[CFG_STEPS_LVL] = CFG_LVL_RST;
        light_on    = 1'b0;
        level_reg   = LEVEL_FULL;
        shown       = '0;
        from_duty   = '0;
        to_duty     = '0;
        step_pos    = '0;
        step_total  = '0;
        fade_busy   = 1'b0;
        routed      = 1'b1;
        saved_ok    = 1'b0;
        saved_on    = 1'b0;
        saved_level = LEVEL_FULL;
        fault_in    = 1'b0;
    endfunction

    // level*100/254, level 0 falls out as 0
    function automatic logic [DUTY_W-1:0] pct_of_level(input logic [LEVEL_W-1:0] lv);
        int unsigned scaled;
        scaled = 32'(lv) * 100;
        return DUTY_W'(scaled / 254);
    endfunction

    // 16-bit smoothstep of pos/span, full scale at or past the end
    function automatic longint unsigned ease_curve(input logic [STEP_W-1:0] pos,
                                                   input logic [STEP_W-1:0] span);
        longint unsigned t;
        longint unsigned t2;
        if (span == '0 || pos >= span)
            return 64'd65535;
        t  = (64'(pos) * 64'd65535) / 64'(span);
        t2 = (t * t) / 64'd65535;
        return (t2 * (64'd196605 - 2 * t)) / 64'd65535;
    endfunction

    // Duty at a fade position; signed division truncates towards zero
    function automatic logic [DUTY_W-1:0] fade_point(input logic [STEP_W-1:0] pos);
        longint ease;
        longint span_delta;
        longint point;
        if (step_total == '0 || pos >= step_total)
            return to_duty;
        ease       = longint'(ease_curve(pos, step_total));
        span_delta = longint'({1'b0, to_duty}) - longint'({1'b0, from_duty});
        point      = longint'({1'b0, from_duty}) + (span_delta * ease) / 64'sd65535;
        return DUTY_W'(point);
    endfunction

    function automatic void show_frame(input logic [STEP_W-1:0] pos);
        logic [DUTY_W-1:0] d;
        d = fade_point(pos);
        if (fault_in)
            routed = 1'b0;
        else
        begin
            routed = 1'b1;
            shown  = d;
        end
    endfunction

    // Jump straight to the settled duty
    function automatic void settle_now();
        fade_busy = 1'b0;
        if (fault_in)
            routed = 1'b0;
        else
        begin
            routed = 1'b1;
            shown  = light_on ? pct_of_level(level_reg) : '0;
        end
    endfunction

    // A zero register means one tick; lengths beyond the counter saturate
    function automatic logic [STEP_W-1:0] step_len(input logic [CFG_IDX_W-1:0] which);
        if (steps_cfg[which] == '0)
            return STEP_W'(1);
        if (32'(steps_cfg[which]) > 32'(STEP_MAX))
            return STEP_MAX;
        return STEP_W'(steps_cfg[which]);
    endfunction

    function automatic void plan_fade(input logic restart);
        if (fault_in)
        begin
            settle_now();
            return;
        end
        to_duty = light_on ? pct_of_level(level_reg) : '0;
        if (!fade_busy || restart)
            from_duty = shown;
        if (from_duty == to_duty)
        begin
            fade_busy = 1'b0;
            show_frame(step_total);
            return;
        end
        step_pos = '0;
        if (light_on)
            step_total = step_len(restart ? CFG_STEPS_ON : CFG_STEPS_LVL);
        else
            step_total = step_len(CFG_STEPS_OFF);
        fade_busy = 1'b0;
        show_frame('0);
        fade_busy = 1'b1;
    endfunction

    // Advance the dimmer by one item and return the status it reports
    function automatic status_t apply_item(input logic [ACTION_W-1:0] act,
                                           input logic                onv,
                                           input logic [LEVEL_W-1:0]  lvv,
                                           input logic                flt,
                                           input logic                blk);
        status_t st;
        fault_in = flt;
        case (act)
            ACT_SET_POWER:
            begin
                // switching on while protection blocks it is dropped
                if (!(onv && blk))
                begin
                    light_on = onv;
                    if (onv && level_reg <= LEVEL_LOW)
                        level_reg = LEVEL_FULL;
                    plan_fade(1'b1);
                end
            end
            ACT_SET_LEVEL:
            begin
                level_reg = lvv;
                if (light_on)
                    plan_fade(1'b0);
            end
            ACT_TICK:
            begin
                if (!fade_busy || fault_in)
                    fade_busy = 1'b0;
                else
                begin
                    step_pos = step_pos + STEP_W'(1);
                    if (step_pos >= step_total)
                    begin
                        fade_busy = 1'b0;
                        show_frame(step_total);
                    end
                    else
                        show_frame(step_pos);
                end
            end
            ACT_FAULT_OFF:
            begin
                // only the first fault in a row saves the state
                if (!saved_ok)
                begin
                    saved_on    = light_on;
                    saved_level = level_reg;
                    saved_ok    = 1'b1;
                end
                fade_busy = 1'b0;
                light_on  = 1'b0;
                shown     = '0;
                routed    = 1'b0;
            end
            ACT_RECOVER:
            begin
                if (saved_ok)
                begin
                    light_on  = saved_on;
                    level_reg = saved_level;
                    saved_ok  = 1'b0;
                end
                routed = 1'b1;
                settle_now();
            end
            ACT_SYNC:
            begin
                light_on  = onv;
                level_reg = lvv;
                settle_now();
            end
            default:
            begin
            end
        endcase
        st.duty    = routed ? shown : '0;
        st.enabled = routed;
        st.fading  = fade_busy;
        st.on      = light_on;
        st.level   = level_reg;
        return st;
    endfunction

    function automatic void note_mismatch(input string what, input status_t want,
                                          input status_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display({"%0t %s: expected duty %0d en %0b fade %0b on %0b level %0d,",
                      " got duty %0d en %0b fade %0b on %0b level %0d"},
                     $realtime, what, want.duty, want.enabled, want.fading, want.on,
                     want.level, got.duty, got.enabled, got.fading, got.on, got.level);
    endfunction

    // Watch config writes and both channels on every edge
    always @(posedge clk or negedge rst_n)
    begin
        status_t got;
        status_t want;
        if (!rst_n)
        begin
            clear_model();
            status_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STEPS_ON:  steps_cfg[CFG_STEPS_ON]  = cfg_wdata;
                    CFG_STEPS_OFF: steps_cfg[CFG_STEPS_OFF] = cfg_wdata;
                    CFG_STEPS_LVL: steps_cfg[CFG_STEPS_LVL] = cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            if (item_ch.valid && item_ch.ready)
                status_q.push_back(apply_item(item_ch.action, item_ch.on_value,
                                              item_ch.level_value, item_ch.fault_active,
                                              item_ch.turn_on_blocked));
            if (result_ch.valid && result_ch.ready)
            begin
                got.duty    = result_ch.duty_percent;
                got.enabled = result_ch.output_enabled;
                got.fading  = result_ch.fade_running;
                got.on      = result_ch.light_on;
                got.level   = result_ch.level_now;
                if (status_q.size() == 0)
                    note_mismatch("status transfer with none pending", '0, got);
                else
                begin
                    want = status_q.pop_front();
                    if (got.duty !== want.duty || got.enabled !== want.enabled ||
                        got.fading !== want.fading || got.on !== want.on ||
                        got.level !== want.level)
                        note_mismatch("status mismatch", want, got);
                end
            end
            outstanding <= status_q.size();
            fail_count  <= mismatches;
        end
    end

endmodule

/* dv/tb.sv */
// Top of the dimmer fade testbench: clock, reset, config writes, item and result traffic.
module tb;
    import sdf_pkg::*;

    // Action codes the block leaves unused
    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

    localparam int PHASE_ITEMS    = 300;
    localparam int PRESSURE_PHASE = 5;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 100;
    localparam int CYCLE_LIMIT    = 1_500_000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    int fail_count;
    int outstanding;
    int snd_idle;
    int rcv_idle;
    int phase_no;
    int cycle_count;

    sdf_in_if  item_if ();
    sdf_out_if res_if ();

    smoothstep_dimmer_fade i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sdf_fade_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_ch     (item_if),
        .result_ch   (res_if),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off to back the block up
    initial
    begin
        int hold_left;
        bit held;
        hold_left    = 0;
        held         = 1'b0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else if (!held && phase_no == PRESSURE_PHASE)
            begin
                held         = 1'b1;
                hold_left    = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // Offer one item after a random gap and wait for its transfer
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic onv,
                             input logic [LEVEL_W-1:0] lvv, input logic flt,
                             input logic blk);
        int gap;
        gap = 0;
        while ($urandom_range(99) < snd_idle)
            gap++;
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid           <= 1'b1;
        item_if.action          <= act;
        item_if.on_value        <= onv;
        item_if.level_value     <= lvv;
        item_if.fault_active    <= flt;
        item_if.turn_on_blocked <= blk;
        do
            @(posedge clk);
        while (!item_if.ready);
    endtask

    // Stop offering and wait until every status has come back
    task automatic drain();
        item_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Write all three fade lengths back to back; block must be idle
    task automatic write_steps(input logic [CFG_W-1:0] n_on, input logic [CFG_W-1:0] n_off,
                               input logic [CFG_W-1:0] n_lvl);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_STEPS_ON;
        cfg_wdata <= n_on;
        @(posedge clk);
        cfg_index <= CFG_STEPS_OFF;
        cfg_wdata <= n_off;
        @(posedge clk);
        cfg_index <= CFG_STEPS_LVL;
        cfg_wdata <= n_lvl;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random action; ticks come in runs so that fades get to finish
    task automatic random_burst(output int sent);
        int unsigned pick;
        int unsigned run;
        logic [ACTION_W-1:0] act;
        logic [LEVEL_W-1:0]  lvl;
        sent = 0;
        pick = $urandom_range(99);
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(3))
                0:       lvl = '0;
                1:       lvl = 8'd1;
                2:       lvl = LEVEL_FULL;
                default: lvl = '1;
            endcase
        end
        else
            lvl = LEVEL_W'($urandom_range(255));
        if (pick < 46)
        begin
            run = $urandom_range(1, 12);
            repeat (run)
                send_item(ACT_TICK, 1'($urandom_range(1)), LEVEL_W'($urandom_range(255)),
                          $urandom_range(99) < 3, 1'($urandom_range(1)));
            sent = run;
        end
        else
        begin
            if (pick < 60)
                act = ACT_SET_LEVEL;
            else if (pick < 73)
                act = ACT_SET_POWER;
            else if (pick < 81)
                act = ACT_SYNC;
            else if (pick < 87)
                act = ACT_FAULT_OFF;
            else if (pick < 94)
                act = ACT_RECOVER;
            else
                act = $urandom_range(1) ? ACT_SPARE_B : ACT_SPARE_A;
            send_item(act, 1'($urandom_range(1)), lvl, $urandom_range(99) < 10,
                      $urandom_range(99) < 15);
            sent = (act == ACT_SPARE_A || act == ACT_SPARE_B) ? 0 : 1;
        end
    endtask

    task automatic run_phase(input int no, input logic [CFG_W-1:0] n_on,
                             input logic [CFG_W-1:0] n_off, input logic [CFG_W-1:0] n_lvl,
                             input int s_idle, input int r_idle);
        int done;
        int sent;
        drain();
        write_steps(n_on, n_off, n_lvl);
        snd_idle = s_idle;
        rcv_idle = r_idle;
        phase_no = no;
        done     = 0;
        while (done < PHASE_ITEMS)
        begin
            random_burst(sent);
            done += sent;
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_STEPS_ON;
        cfg_wdata               = '0;
        item_if.valid           = 1'b0;
        item_if.action          = ACT_TICK;
        item_if.on_value        = 1'b0;
        item_if.level_value     = '0;
        item_if.fault_active    = 1'b0;
        item_if.turn_on_blocked = 1'b0;
        snd_idle                = 26;
        rcv_idle                = 59;
        phase_no                = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: short fades, a zero level-change length reads as one tick
        write_steps(10'd3, 10'd2, 10'd0);
        send_item(ACT_TICK,      1'b0, 8'd0,       1'b0, 1'b0); // tick while idle
        send_item(ACT_SYNC,      1'b0, 8'd0,       1'b0, 1'b0); // off at level 0
        send_item(ACT_SET_POWER, 1'b1, 8'd0,       1'b0, 1'b1); // blocked turn-on
        send_item(ACT_SET_POWER, 1'b1, 8'd0,       1'b0, 1'b0); // level 0 -> full
        send_item(ACT_TICK,      1'b0, 8'd0,       1'b0, 1'b0);
        send_item(ACT_TICK,      1'b0, 8'd0,       1'b0, 1'b0);
        send_item(ACT_TICK,      1'b0, 8'd0,       1'b0, 1'b0);
        send_item(ACT_SET_LEVEL, 1'b0, 8'd255,     1'b0, 1'b0); // same duty, no fade
        send_item(ACT_SET_LEVEL, 1'b0, 8'd1,       1'b0, 1'b0);
        send_item(ACT_TICK,      1'b0, 8'd0,       1'b0, 1'b0);
        send_item(ACT_SET_LEVEL, 1'b0, 8'd200,     1'b0, 1'b0);
        send_item(ACT_SET_POWER, 1'b0, 8'd0,       1'b0, 1'b0); // turn-off mid-fade
        send_item(ACT_TICK,      1'b0, 8'd0,       1'b1, 1'b0); // tick while faulted
        send_item(ACT_SET_POWER, 1'b1, 8'd0,       1'b0, 1'b0);
        send_item(ACT_FAULT_OFF, 1'b0, 8'd0,       1'b1, 1'b0); // fault during fade
        send_item(ACT_FAULT_OFF, 1'b1, 8'd99,      1'b1, 1'b1); // first save kept
        send_item(ACT_SET_LEVEL, 1'b0, 8'd50,      1'b1, 1'b0); // level only, off
        send_item(ACT_TICK,      1'b0, 8'd0,       1'b1, 1'b0);
        send_item(ACT_RECOVER,   1'b0, 8'd0,       1'b1, 1'b0); // still faulted
        send_item(ACT_FAULT_OFF, 1'b0, 8'd0,       1'b1, 1'b0);
        send_item(ACT_RECOVER,   1'b0, 8'd0,       1'b0, 1'b0);
        send_item(ACT_SYNC,      1'b1, 8'd255,     1'b0, 1'b1);
        send_item(ACT_SPARE_A,   1'b1, 8'd17,      1'b0, 1'b0);
        send_item(ACT_SPARE_B,   1'b0, LEVEL_FULL, 1'b1, 1'b1);
        send_item(ACT_SET_POWER, 1'b0, 8'd0,       1'b0, 1'b1); // off despite block

        // Random phases over several register settings, extremes included
        run_phase(1, 10'd4,    10'd3,    10'd2, 26, 59);
        run_phase(2, 10'd1,    10'd1,    10'd1, 26, 59);
        run_phase(3, 10'd1023, 10'd0,    10'd5, 59, 26);
        run_phase(4, 10'd0,    10'd1023, 10'd7, 59, 26);
        run_phase(PRESSURE_PHASE, 10'd12, 10'd9, 10'd6, 0, 0);
        run_phase(6, 10'd2,    10'd5,    10'd3, 0, 0);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
